// ----- hdl/hch_pkg.sv -----
// ----------------------------------------------------------------------------
// hch_pkg: shared types and constants of the HSV colour histogram
// Operation codes, payload structs, controller states and command/status.
// ----------------------------------------------------------------------------
package hch_pkg;

  localparam int CHAN_BITS    = 4;
  localparam int DROP_BITS    = 8 - CHAN_BITS;
  localparam int ADDR_BITS    = 3 * CHAN_BITS;
  localparam int NUM_BINS     = 1 << ADDR_BITS;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [16:0] EMPTY_SHARE = 17'(32'h10000 >> ADDR_BITS);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PROB  = 2'd1,
    OP_MODE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hch_in_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] sample_total;
    logic [16:0] probability;
    logic [7:0]  mode_hue;
    logic [7:0]  mode_sat;
    logic [7:0]  mode_val;
  } hch_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_PROB_RD,
    ST_PROB_DATA,
    ST_DIV,
    ST_MODE_SCAN,
    ST_MODE_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_wr;     // write zero at sweep address
    logic sweep_reset;  // sweep address back to zero
    logic sweep_inc;    // advance sweep address
    logic load_item;    // capture input item
    logic add_wr;       // write incremented bin count
    logic prob_load;    // capture bin count, start divider setup
    logic div_step;     // one restoring divide step
    logic mode_cmp;     // compare read data against best
    logic emit;         // drive result strobe
  } cmd_t;

  typedef struct packed {
    logic sweep_last;   // sweep address at final bin
    logic div_last;     // final divide step
  } sts_t;

endpackage

// ----- hdl/hsv_colour_histogram_classifier.sv -----
// ----------------------------------------------------------------------------
// hsv_colour_histogram_classifier: quantized 3D HSV colour histogram
// Adds pixels to a bin memory; answers probability and modal colour queries.
// ----------------------------------------------------------------------------
// channel   signals                 direction  timing
// command   start, busy, cmd        in         taken when start & !busy
// result    done, result            out        one-cycle strobe, no stall
//
// Add reads the bin, then writes it back; probability query runs the
// one-bit-per-cycle restoring divider; mode query reads every bin in turn
// through the single read port of the bin memory.
// After reset a clearing sweep zeroes the memory with busy high.
// Results cannot be stalled: done pulses for one cycle.
// ----------------------------------------------------------------------------
module hsv_colour_histogram_classifier (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hch_pkg::hch_in_t  cmd,
  output logic              busy,
  output logic              done,
  output hch_pkg::hch_out_t result
);
  import hch_pkg::*;

  cmd_t ctl;
  sts_t sts;
  hch_out_t res;

  // sequence the work
  hch_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (cmd.operation),
    .sts  (sts),
    .cmd  (ctl),
    .busy (busy)
  );

  // hold counts and do the arithmetic
  hch_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .item(cmd),
    .cmd (ctl),
    .sts (sts),
    .res (res)
  );

  // drive each result beat for one cycle
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctl.emit;
    result <= res;
  end

endmodule

// ----- hdl/hch_ctrl.sv -----
// ----------------------------------------------------------------------------
// hch_ctrl: controller of the HSV colour histogram
// Sequence clear sweep, add, probability and mode scan over the bin memory.
// ----------------------------------------------------------------------------
module hch_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    op,
  input  hch_pkg::sts_t sts,
  output hch_pkg::cmd_t cmd,
  output logic          busy
);
  import hch_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        cmd.sweep_reset = 1'b1;
        if (start) begin
          cmd.load_item = 1'b1;
          case (op)
            OP_ADD:  state_next = ST_ADD_RD;
            OP_PROB: state_next = ST_PROB_RD;
            OP_MODE: state_next = ST_MODE_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD:    state_next = ST_ADD_WR;
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PROB_RD:   state_next = ST_PROB_DATA;
      ST_PROB_DATA: begin
        cmd.prob_load = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_MODE_SCAN: begin
        // read data holds the bin at the previous cycle's sweep address
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_next = ST_MODE_LAST;
      end
      ST_MODE_LAST: begin
        cmd.mode_cmp = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_MODE_SCAN) cmd.mode_cmp = 1'b1;
  end

endmodule

// ----- hdl/hch_datapath.sv -----
// ----------------------------------------------------------------------------
// hch_datapath: bin memory, total counter, divider and mode tracker
// ----------------------------------------------------------------------------
module hch_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hch_pkg::hch_in_t  item,
  input  hch_pkg::cmd_t     cmd,
  output hch_pkg::sts_t     sts,
  output hch_pkg::hch_out_t res
);
  import hch_pkg::*;

  logic [31:0] mem [NUM_BINS];
  logic [31:0] rd_data;
  logic [ADDR_BITS-1:0] addr;       // captured item bin
  logic [1:0]  cur_op;
  logic [ADDR_BITS:0]   sweep;      // one extra bit; indexes via part-select
  logic [ADDR_BITS-1:0] scan_addr;  // address of data now on rd_data
  logic [ADDR_BITS-1:0] best_addr;
  logic [31:0] best_cnt;
  logic [31:0] total;
  logic [31:0] cnt;
  logic [48:0] rem;                 // remainder
  logic [48:0] quo;
  logic [5:0]  div_cnt;
  logic [ADDR_BITS-1:0] rd_addr;
  logic        mode_run;
  logic [49:0] trial;

  always_comb begin
    if (cmd.load_item)
      rd_addr = {item.hue[7 -: CHAN_BITS], item.sat[7 -: CHAN_BITS],
                 item.val[7 -: CHAN_BITS]};
    else if (cur_op == OP_MODE)
      rd_addr = sweep[ADDR_BITS-1:0];
    else
      rd_addr = addr;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.clear_wr) mem[sweep[ADDR_BITS-1:0]] <= '0;
    else if (cmd.add_wr && rd_data != COUNT_MAX) mem[addr] <= rd_data + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      total <= '0;
    end else begin
      if (cmd.sweep_reset) sweep <= '0;
      else if (cmd.sweep_inc) sweep <= sweep + 1'b1;
      if (cmd.add_wr && total != COUNT_MAX) total <= total + 32'd1;
    end
  end

  assign sts.sweep_last = (sweep[ADDR_BITS-1:0] == ADDR_BITS'(NUM_BINS - 1));
  assign sts.div_last   = (div_cnt == 6'd0);

  // mode tracker: strict greater keeps the lowest address on ties
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      addr     <= {item.hue[7 -: CHAN_BITS], item.sat[7 -: CHAN_BITS],
                   item.val[7 -: CHAN_BITS]};
      cur_op   <= item.operation;
      mode_run <= 1'b0;
    end else if (cmd.mode_cmp) begin
      scan_addr <= sweep[ADDR_BITS-1:0];
      mode_run  <= 1'b1;
      if (mode_run) begin
        if (!mode_run || rd_data > best_cnt) begin
          best_cnt  <= rd_data;
          best_addr <= scan_addr;
        end
      end else begin
        best_cnt  <= '0;
        best_addr <= '0;
      end
    end
  end

  // restoring divider: (cnt << 16) / total, 49 steps, one bit a cycle
  assign trial = {rem, quo[48]} - {18'd0, total};
  always_ff @(posedge clk) begin
    if (cmd.prob_load) begin
      cnt     <= rd_data;
      rem     <= '0;
      quo     <= {1'b0, rd_data, 16'd0};
      div_cnt <= 6'd48;
    end else if (cmd.div_step) begin
      if (!trial[49]) begin
        rem <= trial[48:0];
        quo <= {quo[47:0], 1'b1};
      end else begin
        rem <= {rem[47:0], quo[48]};
        quo <= {quo[47:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_comb begin
    res = '0;
    res.sample_total = total;
    if (cur_op == OP_MODE) begin
      res.bin_count = best_cnt;
      res.mode_hue  = 8'(best_addr[ADDR_BITS-1 -: CHAN_BITS]) << DROP_BITS;
      res.mode_sat  = 8'(best_addr[2*CHAN_BITS-1 -: CHAN_BITS]) << DROP_BITS;
      res.mode_val  = 8'(best_addr[CHAN_BITS-1:0]) << DROP_BITS;
    end else begin
      res.bin_count = cnt;
      if (total == '0)          res.probability = EMPTY_SHARE;
      else if (quo > 49'(ONE_Q16)) res.probability = ONE_Q16;
      else                      res.probability = quo[16:0];
    end
  end

endmodule

// ----- hdl/hch_checker.sv -----
// ----------------------------------------------------------------------------
// hch_checker: port-level checks of the histogram block
// ----------------------------------------------------------------------------
module hch_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input hch_pkg::hch_in_t  cmd,
  input logic              busy,
  input logic              done,
  input hch_pkg::hch_out_t result
);
  import hch_pkg::*;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_busy_reset: assert property (@(posedge clk)
    $past(rst) |-> busy) else $error("idle after reset");
  a_add_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation == OP_ADD) |=> ##1 !done)
    else $error("result on add");
  a_prob_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> result.probability <= ONE_Q16) else $error("share above one");
endmodule

bind hsv_colour_histogram_classifier hch_checker u_chk (.*);

// ----- tb/sv/tb_hsv_colour_histogram_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_colour_histogram_classifier: self-checking bench of the HSV histogram
// Sends add, probability, mode and unused commands with random gaps, keeps
// a shadow histogram, and compares every result beat against the predicted one.
// ----------------------------------------------------------------------------
module tb_hsv_colour_histogram_classifier;
  import hch_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  hch_in_t  cmd = '0;
  logic     busy;
  logic     done;
  hch_out_t result;

  // Shadow histogram and the queue of results still to come
  logic [31:0] shadow_bins [NUM_BINS];
  logic [31:0] shadow_total;
  hch_out_t    pending_results [$];
  int          fail_count = 0;
  // Hot pixels keep a few bins heavy so that mode queries see real contests
  logic [7:0]  hot_hue [4];
  logic [7:0]  hot_sat [4];
  logic [7:0]  hot_val [4];

  hsv_colour_histogram_classifier DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always #10 clk = ~clk;

  function automatic logic [ADDR_BITS-1:0] bin_of(logic [7:0] h, logic [7:0] s,
                                                  logic [7:0] v);
    return {h[7 -: CHAN_BITS], s[7 -: CHAN_BITS], v[7 -: CHAN_BITS]};
  endfunction

  // Advance the shadow histogram by one command; queue the result it causes
  function automatic void predict_histogram(hch_in_t c);
    hch_out_t r;
    logic [ADDR_BITS-1:0] a;
    logic [63:0] q;
    int best;
    r = '0;
    a = bin_of(c.hue, c.sat, c.val);
    case (op_t'(c.operation))
      OP_ADD: begin
        if (shadow_bins[a] != COUNT_MAX) shadow_bins[a] = shadow_bins[a] + 1;
        if (shadow_total != COUNT_MAX) shadow_total = shadow_total + 1;
      end
      OP_PROB: begin
        r.bin_count = shadow_bins[a];
        r.sample_total = shadow_total;
        if (shadow_total == 0) begin
          r.probability = EMPTY_SHARE;
        end else begin
          q = {shadow_bins[a], 16'h0} / {32'h0, shadow_total};
          r.probability = (q > 64'h10000) ? ONE_Q16 : q[16:0];
        end
        pending_results.insert(pending_results.size(), r);
      end
      OP_MODE: begin
        best = 0;
        for (int i = 1; i < NUM_BINS; i++)
          if (shadow_bins[i] > shadow_bins[best]) best = i;
        r.bin_count = shadow_bins[best];
        r.sample_total = shadow_total;
        r.mode_hue = 8'(((best >> (2 * CHAN_BITS)) % (1 << CHAN_BITS)) << DROP_BITS);
        r.mode_sat = 8'(((best >> CHAN_BITS) % (1 << CHAN_BITS)) << DROP_BITS);
        r.mode_val = 8'((best % (1 << CHAN_BITS)) << DROP_BITS);
        pending_results.insert(pending_results.size(), r);
      end
      default: ;
    endcase
  endfunction

  // Send one command beat after a random gap; hold start until it is taken
  task automatic send_command(op_t op, logic [7:0] h, logic [7:0] s, logic [7:0] v,
                              bit no_gap = 0);
    hch_in_t c;
    int gap;
    c.operation = op;
    c.hue = h;
    c.sat = s;
    c.val = v;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_histogram(c);
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        fail_count++;
      end else begin
        hch_out_t e;
        e = pending_results.pop_front();
        if (result.bin_count !== e.bin_count) begin
          $display("%0t: bin_count exp %h got %h", $time, e.bin_count, result.bin_count);
          fail_count++;
        end
        if (result.sample_total !== e.sample_total) begin
          $display("%0t: sample_total exp %h got %h", $time, e.sample_total,
                   result.sample_total);
          fail_count++;
        end
        if (result.probability !== e.probability) begin
          $display("%0t: probability exp %h got %h", $time, e.probability,
                   result.probability);
          fail_count++;
        end
        if (result.mode_hue !== e.mode_hue) begin
          $display("%0t: mode_hue exp %h got %h", $time, e.mode_hue, result.mode_hue);
          fail_count++;
        end
        if (result.mode_sat !== e.mode_sat) begin
          $display("%0t: mode_sat exp %h got %h", $time, e.mode_sat, result.mode_sat);
          fail_count++;
        end
        if (result.mode_val !== e.mode_val) begin
          $display("%0t: mode_val exp %h got %h", $time, e.mode_val, result.mode_val);
          fail_count++;
        end
      end
    end
  end

  // Empty histogram: uniform share, mode at bin 0, unused code dropped
  task automatic test_empty_histogram();
    send_command(OP_PROB, 8'h00, 8'h00, 8'h00);
    send_command(OP_PROB, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_MODE, 8'hA5, 8'h5A, 8'hFF);
    send_command(OP_NONE, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_PROB, 8'h80, 8'h7F, 8'h01);
  endtask

  // Channel extremes, a tie broken toward the lower bin, a full share
  task automatic test_directed_corners();
    send_command(OP_ADD, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_PROB, 8'hF0, 8'hF0, 8'hF0, 1);
    send_command(OP_MODE, 8'h00, 8'h00, 8'h00);
    send_command(OP_ADD, 8'h0F, 8'h0F, 8'h0F, 1);
    send_command(OP_MODE, 8'h00, 8'h00, 8'h00);
    send_command(OP_PROB, 8'h00, 8'h00, 8'h00);
    send_command(OP_ADD, 8'h55, 8'hAA, 8'h55);
    send_command(OP_ADD, 8'h5F, 8'hA0, 8'h50, 1);
    send_command(OP_NONE, 8'h5F, 8'hA0, 8'h50);
    send_command(OP_PROB, 8'h50, 8'hAF, 8'h5A);
    send_command(OP_MODE, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_PROB, 8'h12, 8'h34, 8'h56);
  endtask

  // Random traffic, adds dominate and cluster on hot pixels
  task automatic test_random_traffic(int n);
    int pick;
    int k;
    logic [7:0] h, s, v;
    for (int i = 0; i < 4; i++) begin
      hot_hue[i] = 8'($urandom);
      hot_sat[i] = 8'($urandom);
      hot_val[i] = 8'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) begin
        h = hot_hue[k] ^ 8'($urandom_range(0, (1 << DROP_BITS) - 1));
        s = hot_sat[k] ^ 8'($urandom_range(0, (1 << DROP_BITS) - 1));
        v = hot_val[k] ^ 8'($urandom_range(0, (1 << DROP_BITS) - 1));
      end else begin
        h = 8'($urandom);
        s = 8'($urandom);
        v = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) send_command(OP_ADD, h, s, v);
      else if (pick < 90) send_command(OP_PROB, h, s, v);
      else if (pick < 96) send_command(OP_MODE, h, s, v);
      else send_command(OP_NONE, h, s, v);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BINS; i++) shadow_bins[i] = '0;
    shadow_total = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_histogram();
    test_directed_corners();
    test_random_traffic(1200);
    start <= 1'b0;
    // Drain: wait for the last result, then wait as long as a mode scan takes
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_BINS + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_hsv_colour_histogram_classifier OK");
    end else begin
      $display("tb_hsv_colour_histogram_classifier NOT OK");
    end
    $finish;
  end

  // Worst case: ~1220 mode scans with gaps, about 100 ms
  initial begin
    #1s;
    $display("tb_hsv_colour_histogram_classifier NOT OK");
    $finish;
  end

endmodule
